// ===== rtl/core/assert_macros.svh =====
// assertion macros included by the congestion window top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at the same edge, disabled during reset
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcw assertion failed");

// implication checked at the next edge, disabled during reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcw assertion failed");

`endif

// ===== rtl/core/tcw_pkg.sv =====
// types, codes and helpers for the congestion window block
`default_nettype none

package tcw_pkg;

	localparam int DW     = 32;
	localparam int SEG_W  = 16;
	localparam int CNT_W  = $clog2(DW);
	localparam int IDX_W  = 2;

	localparam logic [DW-1:0]    WIN_MAX       = '1;
	localparam logic [SEG_W-1:0] RST_SEGMENT   = SEG_W'(536);
	localparam logic [DW-1:0]    RST_WINDOW    = DW'(536);
	localparam logic [DW-1:0]    RST_THRESHOLD = '1;

	typedef enum logic [1:0] {
		OP_ACK     = 2'd0,
		OP_LOSS    = 2'd1,
		OP_RESTART = 2'd2,
		OP_LOAD    = 2'd3
	} opcode_t;

	localparam logic [IDX_W-1:0] CFG_SEGMENT_SIZE      = 2'd0;
	localparam logic [IDX_W-1:0] CFG_INITIAL_WINDOW    = 2'd1;
	localparam logic [IDX_W-1:0] CFG_INITIAL_THRESHOLD = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [SEG_W-1:0] segments_acked;
		logic [DW-1:0]    bytes_in_flight;
		logic [DW-1:0]    window_value;
	} tcw_in_t;

	typedef struct packed {
		logic [DW-1:0]    window_bytes;
		logic [DW-1:0]    threshold_bytes;
		logic [SEG_W-1:0] leftover_acked;
	} tcw_out_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} tcw_div_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] quotient;
	} tcw_div_rsp_t;

	// add with saturation at the window maximum
	function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DW] ? WIN_MAX : s[DW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcw_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module tcw_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tcw_pkg::tcw_div_req_t req,
	output tcw_pkg::tcw_div_rsp_t      rsp
);
	import tcw_pkg::*;

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             running_q;
	logic             done_q;

	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			// pulses for one cycle after the last quotient bit
			done_q <= running_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				running_q <= 1'b1;
				cnt_q     <= '1;
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (running_q) begin
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/tcp_congestion_window.sv =====
// top level of the tcp congestion window and slow-start threshold block
`default_nettype none

// NewReno-style congestion window keeper. Each input beat is one event (ack, loss,
// restart or window load) and yields exactly one output beat with the window and
// threshold after the event, plus the segments left after the slow-start step.
// Events are handled one at a time: in_stall is high from acceptance until the
// result is moved into the output register. Loss, restart and load pass through
// S_SLOW and S_DONE; an ack that stays out of congestion avoidance through
// S_SLOW, S_AVOID and S_DONE; one in avoidance with a nonzero window also waits
// in S_DIV on the radix-2 divider that computes segment_size*segment_size / window
// one quotient bit per cycle (32 steps). The input opens again as the result
// enters the output register; S_DONE waits while a stalled result still holds it.
// The next event is accepted while the previous result still waits in the
// output register. Configuration must be written through cfg_we / cfg_index /
// cfg_data only while idle; the block does not enforce this. Writes to an index
// beyond the register list are ignored.
module tcp_congestion_window (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input beats
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire tcw_pkg::tcw_in_t               in_data,
	// output beats
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output tcw_pkg::tcw_out_t                   out_data,
	// configuration writes
	input  wire logic                           cfg_we,
	input  wire logic [tcw_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [tcw_pkg::DW-1:0]         cfg_data
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLOW,
		S_AVOID,
		S_DIV,
		S_DONE
	} state_t;

	state_t           state_q;

	// configuration registers
	logic [SEG_W-1:0] seg_q;
	logic [DW-1:0]    init_win_q;
	logic [DW-1:0]    init_ssth_q;

	// block state
	logic [DW-1:0]    win_q;
	logic [DW-1:0]    ssth_q;

	// captured event
	logic [1:0]       op_q;
	logic [SEG_W-1:0] left_q;
	logic [DW-1:0]    flight_q;
	logic [DW-1:0]    wval_q;

	// output register
	logic             out_valid_q;
	tcw_out_t         out_q;

	tcw_div_req_t     div_req;
	tcw_div_rsp_t     div_rsp;

	logic             in_beat;
	logic             out_free;
	logic             avoid_go;
	logic [DW-1:0]    two_seg;
	logic [DW-1:0]    half_flight;
	logic [DW-1:0]    inc;
	logic [DW-1:0]    seg_sq;

	assign in_stall = (state_q != S_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// congestion avoidance applies once the window reached the threshold with segments left
	assign avoid_go = (win_q >= ssth_q) && (left_q != '0);

	assign two_seg     = {{(DW-SEG_W-1){1'b0}}, seg_q, 1'b0};
	assign half_flight = flight_q >> 1;

	// a zero quotient still grows the window by one byte
	assign inc = (div_rsp.quotient == '0) ? DW'(1) : div_rsp.quotient;

	// full 32-bit square of the segment size, never overflows
	assign seg_sq = {{(DW-SEG_W){1'b0}}, seg_q} * {{(DW-SEG_W){1'b0}}, seg_q};

	// divider started for seg*seg / window, divisor known nonzero here
	assign div_req.start    = (state_q == S_AVOID) && avoid_go && (win_q != '0);
	assign div_req.dividend = seg_sq;
	assign div_req.divisor  = win_q;

	tcw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= RST_SEGMENT;
			init_win_q  <= RST_WINDOW;
			init_ssth_q <= RST_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SEGMENT_SIZE:      seg_q       <= cfg_data[SEG_W-1:0];
				CFG_INITIAL_WINDOW:    init_win_q  <= cfg_data;
				CFG_INITIAL_THRESHOLD: init_ssth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured event payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q     <= in_data.opcode;
			flight_q <= in_data.bytes_in_flight;
			wval_q   <= in_data.window_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= RST_WINDOW;
			ssth_q      <= RST_THRESHOLD;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// a new result refills the register in the cycle the old beat leaves
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						// only acks report leftover segments
						left_q  <= (in_data.opcode == OP_ACK) ? in_data.segments_acked : '0;
						state_q <= S_SLOW;
					end
				end
				S_SLOW: begin
					state_q <= (op_q == OP_ACK) ? S_AVOID : S_DONE;
					unique case (op_q)
						OP_ACK: begin
							// slow start step consumes one segment
							if ((win_q < ssth_q) && (left_q != '0)) begin
								win_q  <= sat_add(win_q, {{(DW-SEG_W){1'b0}}, seg_q});
								left_q <= left_q - 1'b1;
							end
						end
						OP_LOSS:    ssth_q <= (two_seg > half_flight) ? two_seg : half_flight;
						OP_RESTART: begin
							win_q  <= init_win_q;
							ssth_q <= init_ssth_q;
						end
						OP_LOAD:    win_q <= wval_q;
						default: ;
					endcase
				end
				S_AVOID: begin
					if (avoid_go && (win_q != '0)) begin
						state_q <= S_DIV;
					end else begin
						// zero window takes the maximum increment
						if (avoid_go) begin
							win_q <= WIN_MAX;
						end
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						win_q   <= sat_add(win_q, inc);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q.window_bytes    <= win_q;
						out_q.threshold_bytes <= ssth_q;
						out_q.leftover_acked  <= left_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "assert_macros.svh"

	// an accepted beat always starts work
	`TCW_ASSERT_NEXT(a_beat_starts, clk, arst_n, in_beat, state_q == S_SLOW)
	// the divider only finishes while the sequencer waits for it
	`TCW_ASSERT_NOW(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == S_DIV)
	// never divide by a zero window
	`TCW_ASSERT_NOW(a_div_nonzero, clk, arst_n, state_q == S_DIV, win_q != '0)
	// a result is written only into a free output register
	`TCW_ASSERT_NOW(a_done_free, clk, arst_n, (state_q == S_DONE) && out_free, !(out_valid_q && out_stall))

endmodule

`default_nettype wire

// ===== verif/tcw_window_checker.sv =====
// checker for the congestion window block: predicts each result beat and compares it
module tcw_window_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_stall,
	input  wire tcw_pkg::tcw_in_t          in_data,
	input  wire logic                      out_valid,
	input  wire logic                      out_stall,
	input  wire tcw_pkg::tcw_out_t         out_data,
	input  wire logic                      cfg_we,
	input  wire logic [tcw_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [tcw_pkg::DW-1:0]    cfg_data,
	output int                             fail_count,
	output int                             pending
);
	import tcw_pkg::*;

	logic [SEG_W-1:0] seg_size;
	logic [DW-1:0]    init_window;
	logic [DW-1:0]    init_threshold;
	logic [DW-1:0]    cwnd;
	logic [DW-1:0]    ssthresh;
	tcw_out_t         expected_results[$];

	// overflow happens exactly when the increment exceeds the headroom ~w
	function automatic logic [DW-1:0] grow_window(input logic [DW-1:0] w,
	                                              input logic [DW-1:0] inc);
		return (inc > ~w) ? '1 : w + inc;
	endfunction

	function automatic tcw_out_t apply_event(input tcw_in_t ev);
		tcw_out_t         res;
		logic [SEG_W-1:0] left;
		logic [DW-1:0]    square;
		logic [DW-1:0]    quot;
		logic [DW-1:0]    step;
		logic [DW-1:0]    twice_seg;
		logic [DW-1:0]    half_flight;
		left = '0;
		case (ev.opcode)
		OP_ACK: begin
			left = ev.segments_acked;
			if (cwnd < ssthresh && left != '0) begin
				cwnd = grow_window(cwnd, DW'(seg_size));
				left = left - 1'b1;
			end
			if (cwnd >= ssthresh && left != '0) begin
				if (cwnd == '0) begin
					step = '1;
				end else begin
					square = DW'(seg_size) * DW'(seg_size);
					quot   = square / cwnd;
					step   = (quot == '0) ? DW'(1) : quot;
				end
				cwnd = grow_window(cwnd, step);
			end
		end
		OP_LOSS: begin
			twice_seg   = DW'(seg_size) << 1;
			half_flight = ev.bytes_in_flight >> 1;
			ssthresh    = (twice_seg > half_flight) ? twice_seg : half_flight;
		end
		OP_RESTART: begin
			cwnd     = init_window;
			ssthresh = init_threshold;
		end
		default: begin
			cwnd = ev.window_value;
		end
		endcase
		res.window_bytes    = cwnd;
		res.threshold_bytes = ssthresh;
		res.leftover_acked  = left;
		return res;
	endfunction

	function automatic int field_differs(input string label, input logic [DW-1:0] want,
	                                     input logic [DW-1:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		tcw_out_t want;
		int       errs;
		if (!arst_n) begin
			seg_size       = RST_SEGMENT;
			init_window    = RST_WINDOW;
			init_threshold = RST_THRESHOLD;
			cwnd           = RST_WINDOW;
			ssthresh       = RST_THRESHOLD;
			expected_results.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_index)
				CFG_SEGMENT_SIZE:      seg_size = cfg_data[SEG_W-1:0];
				CFG_INITIAL_WINDOW:    init_window = cfg_data;
				CFG_INITIAL_THRESHOLD: init_threshold = cfg_data;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %0d %0d %0d",
						$time, out_data.window_bytes, out_data.threshold_bytes,
						out_data.leftover_acked);
					errs++;
				end else begin
					want = expected_results.pop_front();
					errs += field_differs("window_bytes", want.window_bytes,
						out_data.window_bytes);
					errs += field_differs("threshold_bytes", want.threshold_bytes,
						out_data.threshold_bytes);
					errs += field_differs("leftover_acked", DW'(want.leftover_acked),
						DW'(out_data.leftover_acked));
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_event(in_data));
			fail_count <= fail_count + errs;
			pending    <= expected_results.size();
		end
	end

endmodule

// ===== verif/tcp_congestion_window_tb.sv =====
// testbench top for the congestion window block: stimulus, idling and verdict
module tcp_congestion_window_tb;
	import tcw_pkg::*;

	// run shape
	localparam int LIMIT_CYCLES     = 1000000;
	localparam int RANDOM_PHASES    = 6;
	localparam int EVENTS_PER_PHASE = 300;
	// long receiver hold-off, placed inside a random phase
	localparam int HOLD_CYCLES      = 400;
	localparam int HOLD_AT_EVENT    = 700;
	// outlasts an ack in congestion avoidance, so this covers any straggler
	localparam int SETTLE_CYCLES    = 64;
	// index past the register list, writes to it are dropped by the block
	localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_pattern_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	tcw_in_t          in_data;
	logic             out_valid;
	logic             out_stall;
	tcw_out_t         out_data;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [DW-1:0]    cfg_data;

	int fail_count;
	int pending;
	int cycles      = 0;
	int events_sent = 0;
	int burst_left  = 0;
	int gap_max     = 3;
	bit held_off    = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tcp_congestion_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcw_window_checker window_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// build one event; the field that the opcode uses gets arg, the others get noise
	function automatic tcw_in_t make_event(input opcode_t op, input logic [DW-1:0] arg);
		tcw_in_t ev;
		ev.opcode          = op;
		ev.segments_acked  = SEG_W'($urandom);
		ev.bytes_in_flight = $urandom;
		ev.window_value    = $urandom;
		case (op)
		OP_ACK:  ev.segments_acked = arg[SEG_W-1:0];
		OP_LOSS: ev.bytes_in_flight = arg;
		OP_LOAD: ev.window_value = arg;
		default: ;
		endcase
		return ev;
	endfunction

	// acks dominate since they carry the slow start and avoidance arithmetic;
	// loads park the window at odd spots so later acks land in avoidance
	function automatic tcw_in_t random_event();
		int            roll;
		int            pick;
		logic [DW-1:0] arg;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		if (roll < 55) begin
			if (pick < 6)
				arg = $urandom_range(0, 3);
			else if (pick < 8)
				arg = $urandom_range(4, 64);
			else if (pick == 8)
				arg = $urandom;
			else
				arg = 32'h0000_FFFF;
			return make_event(OP_ACK, arg);
		end
		if (roll < 70) begin
			if (pick < 4)
				arg = $urandom;
			else if (pick < 7)
				arg = $urandom_range(0, 262144);
			else if (pick == 7)
				arg = '0;
			else
				arg = '1;
			return make_event(OP_LOSS, arg);
		end
		if (roll < 80)
			return make_event(OP_RESTART, '0);
		if (pick == 0)
			arg = '0;
		else if (pick < 5)
			arg = $urandom_range(1, 300000);
		else if (pick < 8)
			arg = $urandom;
		else
			arg = '1 - DW'($urandom_range(0, 70000));
		return make_event(OP_LOAD, arg);
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// segment size register is 16 bits wide; upper data bits are noise it must drop
	task automatic load_config(input logic [SEG_W-1:0] seg, input logic [DW-1:0] iw,
	                           input logic [DW-1:0] ithr);
		write_reg(CFG_SEGMENT_SIZE, {SEG_W'($urandom), seg});
		write_reg(CFG_INITIAL_WINDOW, iw);
		write_reg(CFG_INITIAL_THRESHOLD, ithr);
		cfg_we <= 1'b0;
	endtask

	// offer one beat and hold it until the block takes it, then maybe open a gap
	task automatic send_event(input tcw_in_t ev);
		int gap;
		in_data  <= ev;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		events_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// sender goes quiet until every expected result beat has come back;
	// pending is updated at the edge, so it is first read at the next edge
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// receiver: stall patterns of its own, plus one long hold-off mid run
	initial begin
		stall_pattern_t mode;
		int             run;
		bit             level;
		run   = 0;
		level = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = stall_pattern_t'($urandom_range(0, 3));
			repeat ($urandom_range(16, 160)) begin
				// block fills up behind this and must stall its input
				if (!held_off && events_sent >= HOLD_AT_EVENT) begin
					held_off = 1'b1;
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
				STALL_NONE:  level = 1'b0;
				STALL_LIGHT: level = ($urandom_range(0, 3) == 0);
				STALL_HEAVY: level = ($urandom_range(0, 3) != 0);
				default: begin
					if (run == 0) begin
						level = !level;
						run   = $urandom_range(1, 8);
					end else begin
						run--;
					end
				end
				endcase
				out_stall <= level;
				@(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [SEG_W-1:0] new_seg;
		logic [DW-1:0]    new_iw;
		logic [DW-1:0]    new_ithr;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: segment 536, window 536, threshold at max
		send_event(make_event(OP_ACK, 32'd0));          // nothing acked
		send_event(make_event(OP_ACK, 32'd1));          // one slow start step
		send_event(make_event(OP_ACK, 32'h0000_FFFF)); // max acked, slow start only
		send_event(make_event(OP_LOSS, 32'd0));         // twice the segment wins
		send_event(make_event(OP_ACK, 32'd5));          // avoidance only, window already past threshold
		send_event(make_event(OP_LOSS, '1));            // half of max in flight wins
		send_event(make_event(OP_RESTART, '0));
		send_event(make_event(OP_LOAD, 32'hFFFF_FF00));
		send_event(make_event(OP_ACK, 32'd2));          // saturates in both steps
		send_event(make_event(OP_LOAD, 32'd0));
		send_event(make_event(OP_ACK, 32'd1));          // slow start from empty window
		drain();

		// widest segment, smallest window, zero threshold
		write_reg(CFG_UNUSED, $urandom);
		load_config(16'hFFFF, 32'd1, 32'd0);
		send_event(make_event(OP_RESTART, '0));
		send_event(make_event(OP_ACK, 32'd1));          // avoidance with huge quotient
		send_event(make_event(OP_ACK, 32'd0));
		send_event(make_event(OP_LOAD, 32'd0));
		send_event(make_event(OP_ACK, 32'd2));          // zero window jumps to max
		send_event(make_event(OP_LOSS, 32'd0));
		send_event(make_event(OP_LOAD, 32'h0001_0000));
		send_event(make_event(OP_ACK, 32'd1));
		drain();

		// zero segment size, window and threshold at max
		load_config(16'd0, '1, '1);
		send_event(make_event(OP_RESTART, '0));
		send_event(make_event(OP_ACK, 32'd4));          // quotient zero, step of one
		send_event(make_event(OP_LOAD, 32'd100));
		send_event(make_event(OP_ACK, 32'd3));          // slow start adds nothing
		send_event(make_event(OP_LOSS, 32'd3));         // half of flight beats zero
		send_event(make_event(OP_ACK, 32'd2));
		drain();

		// random phases, each with its own register settings and gap profile
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 7))
			0:       new_seg = '0;
			1:       new_seg = '1;
			2:       new_seg = 16'd1;
			3, 4:    new_seg = $urandom_range(500, 1500);
			default: new_seg = SEG_W'($urandom);
			endcase
			case ($urandom_range(0, 7))
			0:       new_iw = 32'd1;
			1:       new_iw = '1;
			2, 3:    new_iw = $urandom;
			default: new_iw = $urandom_range(1, 100000);
			endcase
			case ($urandom_range(0, 7))
			0:       new_ithr = '0;
			1:       new_ithr = '1;
			2, 3:    new_ithr = $urandom;
			default: new_ithr = $urandom_range(1000, 2000000);
			endcase
			load_config(new_seg, new_iw, new_ithr);
			// every third phase runs back to back with no sender gaps
			gap_max = (ph % 3 == 0) ? 0 : ph * 4;
			send_event(make_event(OP_RESTART, '0));
			repeat (EVENTS_PER_PHASE)
				send_event(random_event());
			drain();
		end

		// catch any extra result beat
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
